>>> rtl/core/spi_se_pkg.sv
// Package for the SPI master shift engine: word types, register indexes and helpers.
package spi_se_pkg;

    localparam int MAX_BITS = 32;
    localparam int CNT_W = 6;
    localparam int DATA_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SPI_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MSB_FIRST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEF_COUNT = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_RESET = 6'd8;

    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] tx_data;
        logic [CNT_W-1:0]  bit_count;
        logic              wait_release;
        logic              miso_level;
    } t_in_word;

    typedef struct packed {
        logic              sclk_level;
        logic              mosi_level;
        logic              busy_res;
        logic [DATA_W-1:0] rx_data;
        logic              done_res;
    } t_out_word;

    // ((c - 1) mod 32) + 1, so zero maps to 32
    function automatic logic [CNT_W-1:0] norm_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] m;
        m = c - 6'd1;
        return {1'b0, m[4:0]} + 6'd1;
    endfunction

    function automatic logic [CNT_W-1:0] cur_index(input logic [CNT_W-1:0] left,
                                                    input logic [CNT_W-1:0] len,
                                                    input logic msb);
        return msb ? (left - 6'd1) : (len - left);
    endfunction

    function automatic logic tx_bit(input logic [DATA_W-1:0] w,
                                    input logic [CNT_W-1:0] idx);
        return idx[5] ? 1'b0 : w[idx[4:0]];
    endfunction

endpackage

>>> rtl/core/spi_master_shift_engine_unit.sv
// SPI master shift engine, modes 0 to 3, one start or half-clock tick per word.
//
//  channel | direction | handshake           | payload
//  in      | input     | i_in_valid/o_in_stall | i_in_word  (t_in_word)
//  out     | output    | o_out_valid/i_out_stall | o_out_word (t_out_word)
//  cfg     | input     | i_cfg_we            | i_cfg_index, i_cfg_data
//
// Each word is handled at once: the state registers and the result register
// load at the same edge, so a new word is taken every cycle unless the input stalls.
// A result waits in the output register; input stalls only while it is held.
// Synchronous active-low reset sets all state but the result data; the held result is dropped.
module spi_master_shift_engine_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  spi_se_pkg::t_in_word               i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output spi_se_pkg::t_out_word              o_out_word,
    input  logic                               i_cfg_we,
    input  logic [spi_se_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [spi_se_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [1:0]                     r_spi_mode;
    logic                           r_msb_first;
    logic [spi_se_pkg::CNT_W-1:0]   r_def_count;
    logic [spi_se_pkg::DATA_W-1:0]  r_tx_word,  n_tx_word;
    logic [spi_se_pkg::DATA_W-1:0]  r_rx_word,  n_rx_word;
    logic [spi_se_pkg::CNT_W-1:0]   r_bits_left, n_bits_left;
    logic [spi_se_pkg::CNT_W-1:0]   r_word_len, n_word_len;
    logic                           r_half,     n_half;
    logic                           r_busy,     n_busy;
    logic                           r_wait,     n_wait;
    logic                           r_waiting,  n_waiting;
    logic                           r_sclk,     n_sclk;
    logic                           r_mosi,     n_mosi;
    logic                           n_done;
    logic                           r_out_valid;
    spi_se_pkg::t_out_word          r_out_word;
    logic                           in_accept;
    logic                           cpol, cpha;
    logic [spi_se_pkg::CNT_W-1:0]   idx;
    logic [spi_se_pkg::CNT_W-1:0]   left_dec;
    logic                           sclk_flip;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign cpol        = r_spi_mode[1];
    assign cpha        = r_spi_mode[0];
    assign idx         = spi_se_pkg::cur_index(r_bits_left, r_word_len, r_msb_first);
    assign left_dec    = r_bits_left - 6'd1;
    // polarity change toggles SCLK (old idle level to new) unless a word is accepted
    assign sclk_flip   = i_cfg_we && (i_cfg_index == spi_se_pkg::REG_SPI_MODE)
                         && (i_cfg_data[1] != r_spi_mode[1]);

    always_comb begin
        logic [spi_se_pkg::CNT_W-1:0] len;
        n_tx_word   = r_tx_word;
        n_rx_word   = r_rx_word;
        n_bits_left = r_bits_left;
        n_word_len  = r_word_len;
        n_half      = r_half;
        n_busy      = r_busy;
        n_wait      = r_wait;
        n_waiting   = r_waiting;
        n_sclk      = r_sclk;
        n_mosi      = r_mosi;
        n_done      = 1'b0;
        len = (i_in_word.bit_count == '0) ? r_def_count
                                           : spi_se_pkg::norm_count(i_in_word.bit_count);
        if (i_in_word.op == spi_se_pkg::OP_START) begin
            if (!r_busy) begin
                n_tx_word   = i_in_word.tx_data;
                n_word_len  = len;
                n_bits_left = len;
                n_rx_word   = '0;
                n_half      = 1'b0;
                n_busy      = 1'b1;
                n_wait      = i_in_word.wait_release;
                n_waiting   = 1'b0;
                if (!cpha) begin
                    n_mosi = spi_se_pkg::tx_bit(i_in_word.tx_data,
                        spi_se_pkg::cur_index(len, len, r_msb_first));
                end
            end
        end else if (r_busy) begin
            if (r_waiting) begin
                if (!i_in_word.miso_level) begin
                    n_waiting = 1'b0;
                    n_busy    = 1'b0;
                    n_done    = 1'b1;
                end
            end else if (r_bits_left != '0) begin
                if (!r_half) begin
                    n_sclk = !cpol;
                    if (!cpha) begin
                        if (!idx[5]) begin
                            n_rx_word[idx[4:0]] = r_rx_word[idx[4:0]] | i_in_word.miso_level;
                        end
                    end else begin
                        n_mosi = spi_se_pkg::tx_bit(r_tx_word, idx);
                    end
                    n_half = 1'b1;
                end else begin
                    n_sclk = cpol;
                    if (cpha && !idx[5]) begin
                        n_rx_word[idx[4:0]] = r_rx_word[idx[4:0]] | i_in_word.miso_level;
                    end
                    n_half      = 1'b0;
                    n_bits_left = left_dec;
                    if (left_dec != '0) begin
                        if (!cpha) begin
                            n_mosi = spi_se_pkg::tx_bit(r_tx_word,
                                spi_se_pkg::cur_index(left_dec, r_word_len, r_msb_first));
                        end
                    end else if (r_wait) begin
                        n_waiting = 1'b1;
                    end else begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
            end else begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spi_mode  <= 2'd0;
            r_msb_first <= 1'b1;
            r_def_count <= spi_se_pkg::COUNT_RESET;
            r_tx_word   <= '0;
            r_rx_word   <= '0;
            r_bits_left <= '0;
            r_word_len  <= spi_se_pkg::COUNT_RESET;
            r_half      <= 1'b0;
            r_busy      <= 1'b0;
            r_wait      <= 1'b0;
            r_waiting   <= 1'b0;
            r_sclk      <= 1'b0;
            r_mosi      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    spi_se_pkg::REG_SPI_MODE: r_spi_mode <= i_cfg_data[1:0];
                    spi_se_pkg::REG_MSB_FIRST: r_msb_first <= i_cfg_data[0];
                    spi_se_pkg::REG_DEF_COUNT: r_def_count <= spi_se_pkg::norm_count(i_cfg_data);
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_sclk <= n_sclk;
            end else if (sclk_flip) begin
                r_sclk <= !r_sclk;
            end
            if (in_accept) begin
                r_tx_word   <= n_tx_word;
                r_rx_word   <= n_rx_word;
                r_bits_left <= n_bits_left;
                r_word_len  <= n_word_len;
                r_half      <= n_half;
                r_busy      <= n_busy;
                r_wait      <= n_wait;
                r_waiting   <= n_waiting;
                r_mosi      <= n_mosi;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_word.sclk_level <= n_sclk;
            r_out_word.mosi_level <= n_mosi;
            r_out_word.busy_res   <= n_busy;
            r_out_word.rx_data    <= n_rx_word;
            r_out_word.done_res   <= n_done;
        end
    end

endmodule
